>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker (hmau_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication property, sampled on the rising edge, off during reset.
`define HMAU_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// Next-cycle implication: ante holds now, cons must hold in the next cycle.
`define HMAU_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hmau_pkg.sv
`default_nettype none

package hmau_pkg;

    localparam int TABLE_SLOTS = 4096;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int WORD_W      = 64;
    localparam int ENTRY_W     = 2 * WORD_W;
    localparam int HASH_W      = 32;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [HASH_W-1:0] SLOTS_H    = HASH_W'(TABLE_SLOTS);
    localparam logic [HASH_W-1:0] HASH_MULT  = 32'd2654435761;
    // floor(2^32 / slots): estimate never exceeds the true quotient, short by at most one
    localparam logic [HASH_W-1:0] SLOT_RECIP = HASH_W'((64'd1 << 32) / TABLE_SLOTS);

    // cycles from record transfer until the home slot is settled
    localparam int HCNT_W = 2;
    localparam logic [HCNT_W-1:0] HASH_LAT = 2'd3;

    localparam int NS_PER_PCT = 10000000;
    // 10^7 = 2^7 * 5^7: drop the low seven bits, then divide by the odd part
    localparam int DIV_PRE_SH = 7;
    localparam int DIV_ODD    = NS_PER_PCT >> DIV_PRE_SH;
    localparam int DIV_ODD_W  = $clog2(DIV_ODD);
    localparam int NUM_W      = WORD_W - DIV_PRE_SH;
    localparam int RECIP_SH   = NUM_W + DIV_ODD_W;
    localparam int ACC_W      = 2 * WORD_W;
    localparam int PART_W     = 32;
    // ceil(2^RECIP_SH / odd part): exact floor quotient for every NUM_W-bit numerator
    localparam logic [ACC_W-1:0] RECIP =
        ((ACC_W'(1) << RECIP_SH) + ACC_W'(DIV_ODD - 1)) / ACC_W'(DIV_ODD);
    localparam logic [PART_W-1:0] RECIP_LO = RECIP[PART_W-1:0];
    localparam logic [PART_W-1:0] RECIP_HI = RECIP[2*PART_W-1:PART_W];
    localparam int MUL_STEPS  = 4;
    localparam int MCNT_W     = 2;
    localparam int QUOT_W     = 32;
    localparam int PCT_W      = 7;
    localparam int PCT_MAX    = 100;

    typedef struct packed {
        logic              take_rec;
        logic              take_eop;
        logic              probe_start;
        logic              probe_next;
        logic              check;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_addr;
    } hmau_ctl_t;

    typedef struct packed {
        logic busy_nz;
        logic slot_empty;
        logic key_match;
        logic eop_pend;
    } hmau_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/hashed_max_aggregate_usage.sv
// Record with nonzero busy time: input stalls while the home slot is hashed and the slots
// are probed (one registered table read and one compare/write per slot visited).
// Zero-busy record: taken with no stall. End of pass: result after a reciprocal multiply
// for the divide by 10^7 (four 32x32 steps); input stalls while all TABLE_SLOTS slots are
// swept, one more sweep each time a stalled result outlasts the sweep.
// Reset: control state clears at once, then a sweep of every slot zeroes the table.
`default_nettype none

module hashed_max_aggregate_usage
    import hmau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              cmd,
    input  wire logic [WORD_W-1:0] client_id,
    input  wire logic [WORD_W-1:0] busy_ns,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [WORD_W-1:0]      total_ns,
    output logic [PCT_W-1:0]       usage_pct,
    output logic                   pct_valid
);

    hmau_ctl_t ctl;
    hmau_sts_t sts;

    hmau_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .client_id (client_id),
        .busy_ns   (busy_ns),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .total_ns  (total_ns),
        .usage_pct (usage_pct),
        .pct_valid (pct_valid)
    );

    hmau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

endmodule

`default_nettype wire

>>> hw/rtl/hmau_div.sv
`default_nettype none

// Divide by the fixed ns-per-percent constant: shift out the power of two, then multiply
// by the reciprocal of the odd part, one 32x32 partial product per cycle.
// Keeps only the low QUOT_W quotient bits.
module hmau_div
    import hmau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    output logic                   done,
    output logic [QUOT_W-1:0]      quotient
);

    localparam logic [MCNT_W-1:0] LAST_STEP = MCNT_W'(MUL_STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [MCNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic [PART_W-1:0]   mul_a;
    logic [PART_W-1:0]   mul_b;
    logic [2*PART_W-1:0] prod;
    logic [1:0]          sh_words;
    logic [ACC_W-1:0]    part;

    // step 0: lo*lo, 1: hi*lo, 2: lo*hi, 3: hi*hi
    assign mul_a    = cnt_reg[0] ? PART_W'(num_reg[NUM_W-1:PART_W]) : num_reg[PART_W-1:0];
    assign mul_b    = cnt_reg[1] ? RECIP_HI : RECIP_LO;
    assign prod     = mul_a * mul_b;
    assign sh_words = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
    assign part     = ACC_W'(prod) << (PART_W * sh_words);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[WORD_W-1:DIV_PRE_SH];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + part;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[RECIP_SH +: QUOT_W];

endmodule

`default_nettype wire

>>> hw/rtl/hmau_datapath.sv
`default_nettype none

module hmau_datapath
    import hmau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hmau_ctl_t         ctl,
    output hmau_sts_t              sts,
    input  wire logic [WORD_W-1:0] client_id,
    input  wire logic [WORD_W-1:0] busy_ns,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [WORD_W-1:0]      total_ns,
    output logic [PCT_W-1:0]       usage_pct,
    output logic                   pct_valid
);

    logic [ENTRY_W-1:0] slot_mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [WORD_W-1:0]  id_reg;
    logic [WORD_W-1:0]  busy_reg;
    logic [SLOT_W-1:0]  addr_reg;

    logic [HASH_W-1:0]  hash_reg;
    logic [HASH_W-1:0]  hash_d_reg;
    logic [HASH_W-1:0]  hash_dd_reg;
    logic [HASH_W-1:0]  qest_reg;
    logic [HASH_W-1:0]  qn_reg;

    logic [WORD_W-1:0]  total_reg;
    logic [WORD_W-1:0]  prev_reg;
    logic               have_prev_reg;
    logic               pend_reg;
    logic               pend_pv_reg;
    logic [WORD_W-1:0]  res_total_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_total_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic               out_pv_reg;

    logic [HASH_W-1:0]  hash_next;
    logic [2*HASH_W-1:0] recip_prod;
    logic [2*HASH_W-1:0] qn_prod;
    logic [HASH_W-1:0]  rem;
    logic [HASH_W-1:0]  home;
    logic [SLOT_W-1:0]  next_addr;

    logic [WORD_W-1:0]  rd_key;
    logic [WORD_W-1:0]  rd_busy;
    logic               slot_empty;
    logic               key_match;
    logic               raise;
    logic               do_write;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [WORD_W-1:0]  add_val;

    logic               div_done;
    logic [QUOT_W-1:0]  quot;
    logic [PCT_W-1:0]   pct;
    logic               out_free;
    logic               load_out;

    // hash: low 32 bits of id * multiplier, then mod slots by reciprocal and one correction
    assign hash_next  = id_reg[HASH_W-1:0] * HASH_MULT;
    assign recip_prod = hash_reg * SLOT_RECIP;
    assign qn_prod    = qest_reg * SLOTS_H;
    assign rem        = hash_dd_reg - qn_reg;
    assign home       = (rem >= SLOTS_H) ? (rem - SLOTS_H) : rem;
    assign next_addr  = (addr_reg == LAST_SLOT) ? '0 : (addr_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        hash_reg    <= hash_next;
        hash_d_reg  <= hash_reg;
        hash_dd_reg <= hash_d_reg;
        qest_reg    <= recip_prod[2*HASH_W-1:HASH_W];
        qn_reg      <= qn_prod[HASH_W-1:0];
    end

    assign rd_key     = rd_data_reg[ENTRY_W-1:WORD_W];
    assign rd_busy    = rd_data_reg[WORD_W-1:0];
    assign slot_empty = (rd_busy == '0);
    assign key_match  = (rd_key == id_reg);
    assign raise      = key_match && (busy_reg > rd_busy);

    assign do_write = ctl.clr_en || (ctl.check && (slot_empty || raise));
    assign wr_addr  = ctl.clr_en ? ctl.clr_addr : addr_reg;
    assign wr_data  = ctl.clr_en ? '0 : {id_reg, busy_reg};
    assign add_val  = slot_empty ? busy_reg : (busy_reg - rd_busy);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_rec)
        begin
            id_reg   <= client_id;
            busy_reg <= busy_ns;
        end
        if (ctl.probe_start)
        begin
            addr_reg <= home[SLOT_W-1:0];
        end
        else if (ctl.probe_next)
        begin
            addr_reg <= next_addr;
        end
        if (ctl.take_eop)
        begin
            res_total_reg <= total_reg;
            pend_pv_reg   <= have_prev_reg;
        end
    end

    hmau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.take_eop),
        .dividend (total_reg - prev_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign pct = !pend_pv_reg ? '0 :
                 (quot > QUOT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quot[PCT_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = pend_reg && div_done && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.take_eop)
            begin
                total_reg     <= '0;
                prev_reg      <= total_reg;
                have_prev_reg <= 1'b1;
                pend_reg      <= 1'b1;
            end
            else
            begin
                if (ctl.check && (slot_empty || raise))
                begin
                    total_reg <= total_reg + add_val;
                end
                if (load_out)
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_total_reg <= res_total_reg;
            out_pct_reg   <= pct;
            out_pv_reg    <= pend_pv_reg;
        end
    end

    assign sts.busy_nz    = (busy_ns != '0);
    assign sts.slot_empty = slot_empty;
    assign sts.key_match  = key_match;
    assign sts.eop_pend   = pend_reg;

    assign out_valid = out_valid_reg;
    assign total_ns  = out_total_reg;
    assign usage_pct = out_pct_reg;
    assign pct_valid = out_pv_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hmau_ctrl.sv
`default_nettype none

module hmau_ctrl
    import hmau_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      cmd,
    input  wire hmau_sts_t sts,
    output hmau_ctl_t      ctl,
    output logic           in_stall
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [HCNT_W-1:0] hcnt_reg;
    logic [HCNT_W-1:0] hcnt_next;
    logic [SLOT_W-1:0] pcnt_reg;
    logic [SLOT_W-1:0] pcnt_next;
    logic [SLOT_W-1:0] ccnt_reg;
    logic [SLOT_W-1:0] ccnt_next;

    always_comb
    begin
        state_next = state_reg;
        hcnt_next  = hcnt_reg;
        pcnt_next  = pcnt_reg;
        ccnt_next  = ccnt_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // keeps sweeping while the pass result is not yet loaded into the output register
                ctl.clr_en   = 1'b1;
                ctl.clr_addr = ccnt_reg;
                if (ccnt_reg == LAST_SLOT)
                begin
                    ccnt_next = '0;
                    if (!sts.eop_pend)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ccnt_next = ccnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd)
                    begin
                        ctl.take_eop = 1'b1;
                        ccnt_next    = '0;
                        state_next   = ST_CLEAR;
                    end
                    else if (sts.busy_nz)
                    begin
                        ctl.take_rec = 1'b1;
                        hcnt_next    = '0;
                        state_next   = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hcnt_reg == HASH_LAT)
                begin
                    ctl.probe_start = 1'b1;
                    pcnt_next       = '0;
                    state_next      = ST_READ;
                end
                else
                begin
                    hcnt_next = hcnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ctl.check = 1'b1;
                // full table with no match: record dropped
                if (sts.slot_empty || sts.key_match || (pcnt_reg == LAST_SLOT))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.probe_next = 1'b1;
                    pcnt_next      = pcnt_reg + 1'b1;
                    state_next     = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            hcnt_reg  <= '0;
            pcnt_reg  <= '0;
            ccnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hcnt_reg  <= hcnt_next;
            pcnt_reg  <= pcnt_next;
            ccnt_reg  <= ccnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/hmau_checker.sv
`default_nettype none

`include "assert_macros.svh"

module hmau_checker
    import hmau_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              cmd,
    input wire logic [WORD_W-1:0] client_id,
    input wire logic [WORD_W-1:0] busy_ns,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [WORD_W-1:0] total_ns,
    input wire logic [PCT_W-1:0]  usage_pct,
    input wire logic              pct_valid
);

    `HMAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(total_ns) && $stable(usage_pct) && $stable(pct_valid), "stalled result changed")
    `HMAU_ASSERT(a_pct_range, clk, rst_n, out_valid |-> (usage_pct <= 7'd100), "usage above 100")
    `HMAU_ASSERT(a_first_pass, clk, rst_n, (out_valid && !pct_valid) |-> (usage_pct == '0), "usage on first pass")
    `HMAU_ASSERT_NEXT(a_eop_sweep, clk, rst_n, in_valid && !in_stall && cmd, in_stall, "input open during sweep")

endmodule

bind hashed_max_aggregate_usage hmau_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/hashed_max_aggregate_usage_chk.sv
`default_nettype none

module hashed_max_aggregate_usage_chk
    import hmau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic              cmd,
    input  wire logic [WORD_W-1:0] client_id,
    input  wire logic [WORD_W-1:0] busy_ns,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [WORD_W-1:0] total_ns,
    input  wire logic [PCT_W-1:0]  usage_pct,
    input  wire logic              pct_valid,
    output int                     errors,
    output int                     pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] total;
        logic [PCT_W-1:0]  pct;
        logic              pv;
    } pass_sum_t;

    logic [WORD_W-1:0] slot_id [TABLE_SLOTS];
    logic [WORD_W-1:0] slot_ns [TABLE_SLOTS];
    logic [WORD_W-1:0] last_total;
    logic              seen_pass;
    pass_sum_t         sums_q [$];
    pass_sum_t         want;
    int                miss_cnt;

    function automatic int home_slot(logic [WORD_W-1:0] id);
        logic [WORD_W-1:0] prod;
        prod = id * WORD_W'(HASH_MULT);
        return int'(prod[HASH_W-1:0] % SLOTS_H);
    endfunction

    task automatic clear_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_id[i] = '0;
            slot_ns[i] = '0;
        end
    endtask

    // linear probe: first empty slot is claimed, matching key keeps the max
    task automatic merge_record(logic [WORD_W-1:0] id, logic [WORD_W-1:0] ns);
        int start;
        int idx;
        start = home_slot(id);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            idx = (start + i) % TABLE_SLOTS;
            if (slot_ns[idx] == '0)
            begin
                slot_id[idx] = id;
                slot_ns[idx] = ns;
                return;
            end
            if (slot_id[idx] == id)
            begin
                if (ns > slot_ns[idx])
                    slot_ns[idx] = ns;
                return;
            end
        end
        // table full and key absent: dropped
    endtask

    task automatic close_pass();
        pass_sum_t         r;
        logic [WORD_W-1:0] quot;
        logic [31:0]       q32;
        r.total = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
            r.total += slot_ns[i];
        r.pct = '0;
        r.pv  = seen_pass;
        if (seen_pass)
        begin
            quot = (r.total - last_total) / WORD_W'(NS_PER_PCT);
            q32  = quot[31:0];
            r.pct = (q32 > PCT_MAX) ? PCT_W'(PCT_MAX) : q32[PCT_W-1:0];
        end
        sums_q.push_back(r);
        last_total = r.total;
        seen_pass  = 1'b1;
        clear_table();
    endtask

    task automatic check_field(string field, logic [WORD_W-1:0] want_v,
                               logic [WORD_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            miss_cnt++;
            if (miss_cnt <= 10)
                $display("%0t mismatch on %s: expected %h, got %h",
                         $realtime, field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            last_total = '0;
            seen_pass  = 1'b0;
            sums_q.delete();
            miss_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sums_q.size() == 0)
                begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("%0t unexpected result transfer: total %h pct %0d valid %b",
                                 $realtime, total_ns, usage_pct, pct_valid);
                end
                else
                begin
                    want = sums_q.pop_front();
                    check_field("total_ns", want.total, total_ns);
                    check_field("usage_pct", WORD_W'(want.pct), WORD_W'(usage_pct));
                    check_field("pct_valid", WORD_W'(want.pv), WORD_W'(pct_valid));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cmd)
                    close_pass();
                else if (busy_ns != '0)
                    merge_record(client_id, busy_ns);
            end
            errors  <= miss_cnt;
            pending <= sums_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/hashed_max_aggregate_usage_tb.sv
`default_nettype none

module hashed_max_aggregate_usage_tb;
    import hmau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS = 950;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              cmd       = 1'b0;
    logic [WORD_W-1:0] client_id = '0;
    logic [WORD_W-1:0] busy_ns   = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [WORD_W-1:0] total_ns;
    logic [PCT_W-1:0]  usage_pct;
    logic              pct_valid;
    int                errors;
    int                pending;

    hashed_max_aggregate_usage u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .client_id (client_id),
        .busy_ns   (busy_ns),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .total_ns  (total_ns),
        .usage_pct (usage_pct),
        .pct_valid (pct_valid)
    );

    hashed_max_aggregate_usage_chk u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .client_id (client_id),
        .busy_ns   (busy_ns),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .total_ns  (total_ns),
        .usage_pct (usage_pct),
        .pct_valid (pct_valid),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // low id bits that land on a given home slot (slot count is a power of two)
    function automatic logic [SLOT_W-1:0] low_for_home(logic [SLOT_W-1:0] home);
        logic [31:0] inv;
        inv = HASH_MULT;
        repeat (4)
            inv = inv * (32'd2 - HASH_MULT * inv);
        return SLOT_W'(32'(home) * inv);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] id_with_low(logic [SLOT_W-1:0] low);
        logic [WORD_W-1:0] id;
        id = rand_word();
        id[SLOT_W-1:0] = low;
        return id;
    endfunction

    function automatic logic [WORD_W-1:0] pick_busy();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 12)
            return WORD_W'(1);
        if (r < 16)
            return '1;
        if (r < 24)
            return rand_word();
        return WORD_W'($urandom_range(1, 200_000_000));
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send(logic c, logic [WORD_W-1:0] id, logic [WORD_W-1:0] ns);
        in_valid  <= 1'b1;
        cmd       <= c;
        client_id <= id;
        busy_ns   <= ns;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic rec(logic [WORD_W-1:0] id, logic [WORD_W-1:0] ns);
        send(1'b0, id, ns);
        gap(pick_gap(1'b0));
    endtask

    task automatic end_pass();
        send(1'b1, rand_word(), rand_word());
        gap(pick_gap(1'b0));
    endtask

    initial
    begin
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 400)
                                           : $urandom_range(1, 12)) @(posedge clk);
        forever
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(0, 19) == 0 ? $urandom_range(20, 100)
                                                : $urandom_range(1, 3)) @(posedge clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 400)
                                               : $urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        logic [WORD_W-1:0] id_a;
        logic [WORD_W-1:0] id_b;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] ns;
        logic [WORD_W-1:0] pool [$];
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] low;
        bit                quiet;
        int                sent;
        int                nrec;
        int                r;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // first pass, empty table: no percent yet
        end_pass();
        // delta of exactly 100 percent
        rec('0, WORD_W'(1_000_000_000));
        end_pass();
        // 55 percent
        rec('0, WORD_W'(1_550_000_000));
        end_pass();
        // 101 percent, clamped
        rec('1, WORD_W'(2_560_000_000));
        end_pass();

        // collisions at the last slot wrap to slot 0, then id 0 is pushed further
        id_a = id_with_low(low_for_home(LAST_SLOT));
        id_b = id_with_low(low_for_home(LAST_SLOT));
        rec(id_a, WORD_W'(5));
        rec(id_b, WORD_W'(7));
        rec('0, WORD_W'(3));
        rec('0, WORD_W'(2));
        rec('0, WORD_W'(9));
        rec(id_a, '0);
        rec(id_b, '1);
        rec('1, WORD_W'(1));
        end_pass();
        // total drops: wrapped difference
        rec('0, WORD_W'(1));
        end_pass();
        // just under one percent
        rec(WORD_W'(5), WORD_W'(10_000_000));
        end_pass();
        drain();

        // fill every slot, then an absent key is sent twice and dropped both times
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            ns = rand_word();
            if (ns == '0)
                ns = WORD_W'(1);
            send(1'b0, id_with_low(SLOT_W'(k)), ns);
            gap($urandom_range(0, 15) == 0 ? $urandom_range(1, 3) : 0);
        end
        rec(~client_id, rand_word() | WORD_W'(1));
        rec(client_id, '1);
        end_pass();
        drain();

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            pool.delete();
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 5))
                    0:       home = LAST_SLOT;
                    1:       home = LAST_SLOT - 1'b1;
                    2:       home = '0;
                    default: home = SLOT_W'($urandom);
                endcase
                low = low_for_home(home);
                repeat ($urandom_range(1, 5))
                    pool.push_back(id_with_low(low));
            end
            if ($urandom_range(0, 7) == 0)
                pool.push_back('0);
            if ($urandom_range(0, 7) == 0)
                pool.push_back('1);

            r = $urandom_range(0, 19);
            if (r == 0)
                nrec = 0;
            else if (r == 1)
                nrec = $urandom_range(40, 60);
            else
                nrec = $urandom_range(1, 25);

            repeat (nrec)
            begin
                if ($urandom_range(0, 9) == 0)
                    id = rand_word();
                else
                    id = pool[$urandom_range(0, pool.size() - 1)];
                ns = pick_busy();
                send(1'b0, id, ns);
                if (ns != '0)
                    sent++;
                gap(pick_gap(quiet));
            end
            send(1'b1, rand_word(), rand_word());
            sent++;
            if ($urandom_range(0, 9) == 0)
                drain();
            else
                gap(pick_gap(quiet));
        end

        drain();
        repeat (5000) @(posedge clk);
        if (errors == 0)
            $display("hashed_max_aggregate_usage_tb: PASS");
        else
            $display("hashed_max_aggregate_usage_tb: FAIL");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("hashed_max_aggregate_usage_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
